// File: design/spq_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the sorted priority queue
package spq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 8;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

endpackage

// File: design/spq_in_if.sv
`timescale 1ns / 1ps
// input channel of the sorted priority queue: one push or pop word
interface spq_in_if #(
  parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [KEY_WIDTH-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

// File: design/spq_out_if.sv
`timescale 1ns / 1ps
// result channel of the sorted priority queue: one result word per item
interface spq_out_if #(
  parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = 5
);
  import spq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KEY_WIDTH-1:0] popped_key;
  logic                 popped_valid;
  spq_status_t          status;
  logic [CNT_W-1:0]     fill_count;

  modport source (output valid, output popped_key, output popped_valid, output status,
                  output fill_count, input ready);
  modport sink   (input valid, input popped_key, input popped_valid, input status,
                  input fill_count, output ready);
endinterface

// File: design/spq_core.sv
`timescale 1ns / 1ps
// key memory and insertion sequencer of the sorted priority queue
module spq_core #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst_n,
  spq_in_if.sink    in_word,
  spq_out_if.source res_word
);
  import spq_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_POP,
    S_RESULT
  } state_t;

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rdata_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt;
  logic [KEY_WIDTH-1:0] res_key_r, res_key_nxt;
  logic                 res_pv_r, res_pv_nxt;
  spq_status_t          res_st_r, res_st_nxt;
  logic [CNT_W-1:0]     res_cnt_r, res_cnt_nxt;

  logic [CNT_W-1:0]     cnt_m1;
  logic [CNT_W-1:0]     cnt_p1;

  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign cnt_p1 = cnt_r + CNT_W'(1);

  assign in_word.ready         = (state_r == S_IDLE);
  assign res_word.valid        = (state_r == S_RESULT);
  assign res_word.popped_key   = res_key_r;
  assign res_word.popped_valid = res_pv_r;
  assign res_word.status       = res_st_r;
  assign res_word.fill_count   = res_cnt_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    res_key_nxt = res_key_r;
    res_pv_nxt  = res_pv_r;
    res_st_nxt  = res_st_r;
    res_cnt_nxt = res_cnt_r;
    rd_addr     = idx_r - ADDR_W'(1);
    mem_we      = 1'b0;
    mem_waddr   = idx_r + ADDR_W'(1);
    mem_wdata   = rdata_r;
    case (state_r)
      S_IDLE: begin
        if (in_word.valid) begin
          res_key_nxt = '0;
          res_pv_nxt  = 1'b0;
          res_st_nxt  = ST_OK;
          if (in_word.mode == MODE_POP) begin
            if (cnt_r == '0) begin
              res_st_nxt  = ST_EMPTY;
              res_cnt_nxt = cnt_r;
              state_nxt   = S_RESULT;
            end else begin
              rd_addr     = cnt_m1[ADDR_W-1:0];
              cnt_nxt     = cnt_m1;
              res_cnt_nxt = cnt_m1;
              state_nxt   = S_POP;
            end
          end else begin
            if (cnt_r == CNT_W'(DEPTH)) begin
              res_st_nxt  = ST_FULL;
              res_cnt_nxt = cnt_r;
              state_nxt   = S_RESULT;
            end else begin
              cnt_nxt     = cnt_p1;
              res_cnt_nxt = cnt_p1;
              key_nxt     = in_word.key;
              if (cnt_r == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = in_word.key;
                state_nxt = S_RESULT;
              end else begin
                rd_addr   = cnt_m1[ADDR_W-1:0];
                idx_nxt   = cnt_m1[ADDR_W-1:0];
                state_nxt = S_SCAN;
              end
            end
          end
        end
      end
      S_SCAN: begin
        mem_we = 1'b1;
        if (rdata_r > key_r) begin
          // shift the larger key up one place
          mem_wdata = rdata_r;
          if (idx_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            idx_nxt = idx_r - ADDR_W'(1);
          end
        end else begin
          mem_wdata = key_r;
          state_nxt = S_RESULT;
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = key_r;
        state_nxt = S_RESULT;
      end
      S_POP: begin
        res_key_nxt = rdata_r;
        res_pv_nxt  = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_RESULT: begin
        if (res_word.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    res_key_r <= res_key_nxt;
    res_pv_r  <= res_pv_nxt;
    res_st_r  <= res_st_nxt;
    res_cnt_r <= res_cnt_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("count beyond depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> state_r != S_IDLE)
    else $error("accepted word left the sequencer idle");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && state_r != S_IDLE |-> CNT_W'(mem_waddr) < cnt_r)
    else $error("memory write above the stored keys");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_word.valid && res_word.popped_valid |-> res_word.status == ST_OK)
    else $error("popped key with error status");

  a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |=> $stable(cnt_r))
    else $error("count changed during an item");

endmodule

// File: design/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// sorted priority queue: top level with result output register
// a pop reads the top key, then presents it; a push to an empty queue writes its key and
//   goes straight to the result, as do a push to a full queue and a pop on an empty one;
//   another push walks down the key memory, a read-compare-write of one stored key per cycle
//   shifting up each greater key, then places the new key; new words wait for the result
// reset clears the count and the sequencer; the key memory is not cleared
module sorted_priority_queue_unit #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  spq_in_if.sink    in_chan,
  spq_out_if.source out_chan
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  spq_out_if #(.KEY_WIDTH(KEY_WIDTH), .CNT_W(CNT_W)) res_chan ();

  logic                 out_valid_r;
  logic [KEY_WIDTH-1:0] out_key_r;
  logic                 out_pv_r;
  spq_status_t          out_st_r;
  logic [CNT_W-1:0]     out_cnt_r;

  spq_core #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .CNT_W     (CNT_W)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_chan),
    .res_word (res_chan)
  );

  assign res_chan.ready        = !out_valid_r || out_chan.ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.popped_key   = out_key_r;
  assign out_chan.popped_valid = out_pv_r;
  assign out_chan.status       = out_st_r;
  assign out_chan.fill_count   = out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_chan.ready) begin
      out_valid_r <= res_chan.valid;
    end
    if (res_chan.valid && res_chan.ready) begin
      out_key_r <= res_chan.popped_key;
      out_pv_r  <= res_chan.popped_valid;
      out_st_r  <= res_chan.status;
      out_cnt_r <= res_chan.fill_count;
    end
  end

endmodule
